FILE: hdl/lprb_pkg.sv
// Package for the lidar point ring binner: widths, word types and angle table.
package lprb_pkg;

    localparam int COORD_BITS   = 24;
    localparam int NRM_W        = (COORD_BITS > 31) ? COORD_BITS : 31;
    localparam int AZ_W         = COORD_BITS + 31;
    localparam int RES_W        = NRM_W + 1;
    localparam int RW           = 2 * NRM_W + 2;
    localparam int NORM_STEPS   = 5;
    localparam int NORM_TOP     = 31;
    localparam int PRE_SHIFT    = 10;
    localparam int CW           = RES_W + 13;
    localparam int ANG_W        = 28;
    localparam int VW           = ANG_W + 3;
    localparam int FRAC_BITS    = 20;
    localparam int CORDIC_STEPS = 24;
    localparam int RING_W       = 5;

    localparam int FS  = 1 + NORM_STEPS + 2 + RES_W;
    localparam int SQ0 = 1 + NORM_STEPS + 2;
    localparam int BS  = 1 + CORDIC_STEPS + 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [VW-1:0] BIAS16 = VW'(16) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] BIAS32 = VW'(92) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] UNIT16 = VW'(2) <<< FRAC_BITS;
    localparam logic signed [VW-1:0] UNIT32 = VW'(4) <<< FRAC_BITS;
    localparam int SHIFT16 = FRAC_BITS + 1;
    localparam int SHIFT32 = FRAC_BITS + 2;
    localparam logic [VW-1:0] LINES16 = VW'(16);
    localparam logic [VW-1:0] LINES32 = VW'(32);
    localparam logic [VW-1:0] HALF16  = VW'(8);
    localparam logic [VW-1:0] HALF32  = VW'(16);

    localparam logic signed [ANG_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
        28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121,
        28'sd3750058,  28'sd1876857,  28'sd938658,   28'sd469357,
        28'sd234682,   28'sd117342,   28'sd58671,    28'sd29335,
        28'sd14668,    28'sd7334,     28'sd3667,     28'sd1833,
        28'sd917,      28'sd458,      28'sd229,      28'sd115,
        28'sd57,       28'sd29,       28'sd14,       28'sd7
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         zneg;
        logic                         mzero;
        logic [AZ_W-1:0]              az;
        logic [NRM_W-1:0]             ax;
        logic [NRM_W-1:0]             ay;
        logic [2*NRM_W-1:0]           sqx;
        logic [2*NRM_W-1:0]           sqy;
        logic [RW-1:0]                rem;
        logic [RES_W-1:0]             root;
    } fr_stage_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         zneg;
        logic                         mzero;
        logic [AZ_W-1:0]              az;
        logic [RES_W-1:0]             root;
    } q_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         zneg;
        logic                         drop;
        logic                         zero_z;
        logic signed [CW-1:0]         cx;
        logic signed [CW-1:0]         cy;
        logic signed [ANG_W-1:0]      ang;
    } bk_stage_t;

endpackage

FILE: hdl/lprb_front.sv
// Front pipeline: magnitudes, normalizing shift, squares and integer square root.
module lprb_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [lprb_pkg::COORD_BITS-1:0] x_in,
    input  logic signed [lprb_pkg::COORD_BITS-1:0] y_in,
    input  logic signed [lprb_pkg::COORD_BITS-1:0] z_in,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output lprb_pkg::q_word_t                     push_word
);

    localparam int C = lprb_pkg::COORD_BITS;

    lprb_pkg::fr_stage_t st_reg [lprb_pkg::FS];
    logic [lprb_pkg::FS-1:0] vld_reg;
    logic en;

    function automatic lprb_pkg::fr_stage_t take_in(
        input logic signed [C-1:0] x,
        input logic signed [C-1:0] y,
        input logic signed [C-1:0] z
    );
        lprb_pkg::fr_stage_t r;
        logic [C-1:0] ux;
        logic [C-1:0] uy;
        logic [C-1:0] uz;
        r  = '0;
        ux = x[C-1] ? C'(-x) : C'(x);
        uy = y[C-1] ? C'(-y) : C'(y);
        uz = z[C-1] ? C'(-z) : C'(z);
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.zneg  = z[C-1];
        r.ax    = lprb_pkg::NRM_W'(ux);
        r.ay    = lprb_pkg::NRM_W'(uy);
        r.az    = lprb_pkg::AZ_W'(uz);
        r.mzero = (ux == '0) && (uy == '0);
        return r;
    endfunction

    function automatic lprb_pkg::fr_stage_t norm_step(
        input lprb_pkg::fr_stage_t s,
        input int sh
    );
        lprb_pkg::fr_stage_t r;
        logic [lprb_pkg::NRM_W-1:0] lim;
        r   = s;
        lim = lprb_pkg::NRM_W'(1) << (lprb_pkg::NORM_TOP - sh);
        if (s.ax < lim && s.ay < lim)
        begin
            r.ax = s.ax << sh;
            r.ay = s.ay << sh;
            r.az = s.az << sh;
        end
        return r;
    endfunction

    function automatic lprb_pkg::fr_stage_t sq_step(input lprb_pkg::fr_stage_t s);
        lprb_pkg::fr_stage_t r;
        r     = s;
        r.sqx = s.ax * s.ax;
        r.sqy = s.ay * s.ay;
        return r;
    endfunction

    function automatic lprb_pkg::fr_stage_t sum_step(input lprb_pkg::fr_stage_t s);
        lprb_pkg::fr_stage_t r;
        r      = s;
        r.rem  = lprb_pkg::RW'(s.sqx) + lprb_pkg::RW'(s.sqy);
        r.root = '0;
        return r;
    endfunction

    function automatic lprb_pkg::fr_stage_t sqrt_step(
        input lprb_pkg::fr_stage_t s,
        input int b
    );
        lprb_pkg::fr_stage_t r;
        logic [lprb_pkg::RW-1:0] d;
        r = s;
        d = (lprb_pkg::RW'(s.root) << (b + 1)) + (lprb_pkg::RW'(1) << (2 * b));
        if (s.rem >= d)
        begin
            r.rem  = s.rem - d;
            r.root = s.root | (lprb_pkg::RES_W'(1) << b);
        end
        return r;
    endfunction

    assign en       = !(vld_reg[lprb_pkg::FS-1] && !push_ready);
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[lprb_pkg::FS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < lprb_pkg::FS; k++)
    begin : g_st
        if (k == 0)
        begin : g_in
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= take_in(x_in, y_in, z_in);
                end
            end
        end
        else if (k <= lprb_pkg::NORM_STEPS)
        begin : g_norm
            localparam int SH = (1 << (lprb_pkg::NORM_STEPS - 1)) >> (k - 1);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= norm_step(st_reg[k-1], SH);
                end
            end
        end
        else if (k == lprb_pkg::NORM_STEPS + 1)
        begin : g_sq
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= sq_step(st_reg[k-1]);
                end
            end
        end
        else if (k == lprb_pkg::NORM_STEPS + 2)
        begin : g_sum
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= sum_step(st_reg[k-1]);
                end
            end
        end
        else
        begin : g_sqrt
            localparam int B = lprb_pkg::RES_W - 1 - (k - lprb_pkg::SQ0);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= sqrt_step(st_reg[k-1], B);
                end
            end
        end
    end

    assign push_valid      = vld_reg[lprb_pkg::FS-1];
    assign push_word.x     = st_reg[lprb_pkg::FS-1].x;
    assign push_word.y     = st_reg[lprb_pkg::FS-1].y;
    assign push_word.z     = st_reg[lprb_pkg::FS-1].z;
    assign push_word.zneg  = st_reg[lprb_pkg::FS-1].zneg;
    assign push_word.mzero = st_reg[lprb_pkg::FS-1].mzero;
    assign push_word.az    = st_reg[lprb_pkg::FS-1].az;
    assign push_word.root  = st_reg[lprb_pkg::FS-1].root;

endmodule

FILE: hdl/lprb_queue.sv
// Short word queue between the front and back pipelines.
module lprb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  lprb_pkg::q_word_t push_word,
    output logic              pop_valid,
    input  logic              pop_ready,
    output lprb_pkg::q_word_t pop_word
);

    lprb_pkg::q_word_t mem_reg [lprb_pkg::QDEPTH];
    logic [lprb_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [lprb_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [lprb_pkg::QPTR_W:0]   cnt_reg, cnt_next;
    logic push, pop;

    assign push_ready = (cnt_reg != (lprb_pkg::QPTR_W+1)'(lprb_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == lprb_pkg::QPTR_W'(lprb_pkg::QDEPTH - 1)) ? '0
                                                                          : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == lprb_pkg::QPTR_W'(lprb_pkg::QDEPTH - 1)) ? '0
                                                                          : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_word;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (lprb_pkg::QPTR_W+1)'(lprb_pkg::QDEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule

FILE: hdl/lprb_back.sv
// Back pipeline: steep-point check, CORDIC elevation and ring binning.
module lprb_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   line_mode,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  lprb_pkg::q_word_t                      pop_word,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lprb_pkg::COORD_BITS-1:0] x_out,
    output logic signed [lprb_pkg::COORD_BITS-1:0] y_out,
    output logic signed [lprb_pkg::COORD_BITS-1:0] z_out,
    output logic [lprb_pkg::RING_W-1:0]            ring,
    output logic                                   kept,
    output logic                                   lower_half
);

    localparam int NB = lprb_pkg::BS - 1;

    lprb_pkg::bk_stage_t st_reg [NB];
    logic [lprb_pkg::BS-1:0] vld_reg;
    logic en;

    logic signed [lprb_pkg::COORD_BITS-1:0] xo_reg, yo_reg, zo_reg;
    logic [lprb_pkg::RING_W-1:0] ring_reg, ring_next;
    logic kept_reg, kept_next;
    logic low_reg, low_next;

    function automatic lprb_pkg::bk_stage_t take_q(input lprb_pkg::q_word_t q);
        lprb_pkg::bk_stage_t r;
        logic [lprb_pkg::RES_W:0] az_t;
        r      = '0;
        az_t   = q.az[lprb_pkg::RES_W:0];
        r.x    = q.x;
        r.y    = q.y;
        r.z    = q.z;
        r.zneg = q.zneg;
        r.drop = q.mzero || (q.az > lprb_pkg::AZ_W'({q.root, 1'b0}));
        r.zero_z = (q.az == '0);
        r.cx   = lprb_pkg::CW'(q.root) <<< lprb_pkg::PRE_SHIFT;
        r.cy   = lprb_pkg::CW'(az_t) <<< lprb_pkg::PRE_SHIFT;
        r.ang  = '0;
        return r;
    endfunction

    function automatic lprb_pkg::bk_stage_t cordic_step(
        input lprb_pkg::bk_stage_t s,
        input int i
    );
        lprb_pkg::bk_stage_t r;
        logic signed [lprb_pkg::CW-1:0] xv;
        logic signed [lprb_pkg::CW-1:0] yv;
        logic signed [lprb_pkg::CW-1:0] dx;
        logic signed [lprb_pkg::CW-1:0] dy;
        r  = s;
        xv = s.cx;
        yv = s.cy;
        dx = yv >>> i;
        dy = xv >>> i;
        if (!yv[lprb_pkg::CW-1])
        begin
            r.cx  = xv + dx;
            r.cy  = yv - dy;
            r.ang = s.ang + lprb_pkg::ATAN_DEG[i];
        end
        else
        begin
            r.cx  = xv - dx;
            r.cy  = yv + dy;
            r.ang = s.ang - lprb_pkg::ATAN_DEG[i];
        end
        return r;
    endfunction

    assign en        = !(vld_reg[lprb_pkg::BS-1] && !out_ready);
    assign pop_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[lprb_pkg::BS-2:0], pop_valid};
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_st
        if (k == 0)
        begin : g_in
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= take_q(pop_word);
                end
            end
        end
        else
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= cordic_step(st_reg[k-1], k - 1);
                end
            end
        end
    end

    // ring binning on the finished angle
    always_comb
    begin
        logic signed [lprb_pkg::VW-1:0] a;
        logic signed [lprb_pkg::VW-1:0] v;
        logic signed [lprb_pkg::VW-1:0] unit;
        logic [lprb_pkg::VW-1:0] k;
        logic [lprb_pkg::VW-1:0] lines;
        logic [lprb_pkg::VW-1:0] half;
        a = st_reg[NB-1].zero_z ? '0 : lprb_pkg::VW'(st_reg[NB-1].ang);
        if (st_reg[NB-1].zneg)
        begin
            a = -a;
        end
        if (!line_mode)
        begin
            v     = a + lprb_pkg::BIAS16;
            unit  = lprb_pkg::UNIT16;
            lines = lprb_pkg::LINES16;
            half  = lprb_pkg::HALF16;
            k     = v[lprb_pkg::VW-1] ? '0 : (lprb_pkg::VW'(v) >> lprb_pkg::SHIFT16);
        end
        else
        begin
            v     = (a <<< 1) + a + lprb_pkg::BIAS32;
            unit  = lprb_pkg::UNIT32;
            lines = lprb_pkg::LINES32;
            half  = lprb_pkg::HALF32;
            k     = v[lprb_pkg::VW-1] ? '0 : (lprb_pkg::VW'(v) >> lprb_pkg::SHIFT32);
        end
        kept_next = !st_reg[NB-1].drop && (v > -unit) && (k < lines);
        ring_next = kept_next ? k[lprb_pkg::RING_W-1:0] : '0;
        low_next  = kept_next && (k < half);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xo_reg   <= st_reg[NB-1].x;
            yo_reg   <= st_reg[NB-1].y;
            zo_reg   <= st_reg[NB-1].z;
            ring_reg <= ring_next;
            kept_reg <= kept_next;
            low_reg  <= low_next;
        end
    end

    assign out_valid  = vld_reg[lprb_pkg::BS-1];
    assign x_out      = xo_reg;
    assign y_out      = yo_reg;
    assign z_out      = zo_reg;
    assign ring       = ring_reg;
    assign kept       = kept_reg;
    assign lower_half = low_reg;

`ifndef SYNTHESIS
    a_drop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kept) |-> (ring == '0 && !lower_half))
        else $error("dropped word carries ring or half flag");

    a_low_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && lower_half) |-> kept)
        else $error("lower half set on dropped word");
`endif

endmodule

FILE: hdl/lidar_point_ring_binner.sv
// Top level of the lidar point ring binner.
// Usage:
//   Input channel in_valid/in_ready carries one point word (x_in, y_in, z_in).
//   Output channel out_valid/out_ready returns the same coordinates with ring,
//   kept and lower_half. One output word per input word, in order.
//   cfg_we/cfg_wdata write line_mode (0: 16-line rule, 1: 32-line rule);
//   write it only while the block is empty.
// Throughput: one word per clock when the receiver keeps out_ready high.
// Pipeline: 40 front stages (input, 5 normalize shifts, square, sum, 32
//   square-root bits), then the 4-word queue, then 26 back stages (steep
//   check, 24 CORDIC steps, binning output register).
// Receiver stall: the back pipeline holds; the front keeps running into the
//   queue and stalls, dropping in_ready, only once the queue is full.
// Reset: rst_n clears all valid bits and the queue, and line_mode to 0.
module lidar_point_ring_binner (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [lprb_pkg::COORD_BITS-1:0] x_in,
    input  logic signed [lprb_pkg::COORD_BITS-1:0] y_in,
    input  logic signed [lprb_pkg::COORD_BITS-1:0] z_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lprb_pkg::COORD_BITS-1:0] x_out,
    output logic signed [lprb_pkg::COORD_BITS-1:0] y_out,
    output logic signed [lprb_pkg::COORD_BITS-1:0] z_out,
    output logic [lprb_pkg::RING_W-1:0]            ring,
    output logic                                   kept,
    output logic                                   lower_half
);

    logic line_mode_reg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    lprb_pkg::q_word_t push_word, pop_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            line_mode_reg <= cfg_wdata;
        end
    end

    lprb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_in       (x_in),
        .y_in       (y_in),
        .z_in       (z_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    lprb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    lprb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_mode  (line_mode_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .x_out      (x_out),
        .y_out      (y_out),
        .z_out      (z_out),
        .ring       (ring),
        .kept       (kept),
        .lower_half (lower_half)
    );

endmodule

FILE: dv/tb.sv
// Testbench for the lidar point ring binner: random and directed points against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY   = 66;
    localparam int N_RANDOM  = 1350;
    localparam int CYCLE_LIM = 400000;

    typedef struct packed {
        logic signed [lprb_pkg::COORD_BITS-1:0] x;
        logic signed [lprb_pkg::COORD_BITS-1:0] y;
        logic signed [lprb_pkg::COORD_BITS-1:0] z;
        logic [lprb_pkg::RING_W-1:0]            ring;
        logic                                   kept;
        logic                                   lower;
    } binned_point_t;

    class ring_scoreboard;
        binned_point_t pending[$];
        int            mismatches;
        bit            lines32;

        function automatic longint floor_shift(longint v, int s);
            if (v >= 0)
                return v >>> s;
            return ~((~v) >>> s);
        endfunction

        function automatic longint int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic binned_point_t bin_point(
            logic signed [lprb_pkg::COORD_BITS-1:0] x,
            logic signed [lprb_pkg::COORD_BITS-1:0] y,
            logic signed [lprb_pkg::COORD_BITS-1:0] z);
            binned_point_t   p;
            longint unsigned ax, ay, az, m, r;
            longint          cx, cy, ang, v, unit, k, dx, dy;
            longint          lines;
            p.x = x; p.y = y; p.z = z;
            p.ring = 0; p.kept = 0; p.lower = 0;
            ax = (x < 0) ? -longint'(x) : longint'(x);
            ay = (y < 0) ? -longint'(y) : longint'(y);
            az = (z < 0) ? -longint'(z) : longint'(z);
            m = (ax > ay) ? ax : ay;
            if (m != 0)
            begin
                while (m < (64'd1 << 30))
                begin
                    m = m << 1; ax = ax << 1; ay = ay << 1; az = az << 1;
                end
                r = int_sqrt(ax * ax + ay * ay);
                if (az <= 2 * r)
                begin
                    ang = 0;
                    if (az != 0)
                    begin
                        cx = longint'(r << lprb_pkg::PRE_SHIFT);
                        cy = longint'(az << lprb_pkg::PRE_SHIFT);
                        for (int i = 0; i < lprb_pkg::CORDIC_STEPS; i++)
                        begin
                            dx = floor_shift(cy, i);
                            dy = floor_shift(cx, i);
                            if (cy >= 0)
                            begin
                                cx += dx; cy -= dy;
                                ang += longint'(lprb_pkg::ATAN_DEG[i]);
                            end
                            else
                            begin
                                cx -= dx; cy += dy;
                                ang -= longint'(lprb_pkg::ATAN_DEG[i]);
                            end
                        end
                    end
                    if (z < 0)
                        ang = -ang;
                    if (!lines32)
                    begin
                        v = ang + (64'sd16 << lprb_pkg::FRAC_BITS);
                        unit = 64'sd2 << lprb_pkg::FRAC_BITS;
                        lines = 16;
                    end
                    else
                    begin
                        v = 3 * ang + (64'sd92 << lprb_pkg::FRAC_BITS);
                        unit = 64'sd4 << lprb_pkg::FRAC_BITS;
                        lines = 32;
                    end
                    if (v > -unit)
                    begin
                        k = (v < 0) ? 0 : v / unit;
                        if (k < lines)
                        begin
                            p.kept = 1;
                            p.ring = k[lprb_pkg::RING_W-1:0];
                            p.lower = (k < lines / 2);
                        end
                    end
                end
            end
            return p;
        endfunction

        function void note_point(logic signed [lprb_pkg::COORD_BITS-1:0] x,
                                 logic signed [lprb_pkg::COORD_BITS-1:0] y,
                                 logic signed [lprb_pkg::COORD_BITS-1:0] z);
            pending.insert(pending.size(), bin_point(x, y, z));
        endfunction

        function void check_point(binned_point_t got);
            binned_point_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp x=%0d y=%0d z=%0d ring=%0d kept=%b low=%b,",
                              " got x=%0d y=%0d z=%0d ring=%0d kept=%b low=%b"},
                             want.x, want.y, want.z, want.ring, want.kept, want.lower,
                             got.x, got.y, got.z, got.ring, got.kept, got.lower);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_wdata = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [lprb_pkg::COORD_BITS-1:0] x_in = 0, y_in = 0, z_in = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [lprb_pkg::COORD_BITS-1:0] x_out, y_out, z_out;
    logic [lprb_pkg::RING_W-1:0] ring;
    logic kept, lower_half;

    ring_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_off = 0;
    bit  stall_on = 1;

    lidar_point_ring_binner uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_in(x_in), .y_in(y_in), .z_in(z_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .x_out(x_out), .y_out(y_out), .z_out(z_out),
        .ring(ring), .kept(kept), .lower_half(lower_half)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIM)
        begin
            $display("Test completed with failures");
            $finish;
        end
        if (in_valid && in_ready)
            sb.note_point(x_in, y_in, z_in);
        if (out_valid && out_ready)
            sb.check_point({x_out, y_out, z_out, ring, kept, lower_half});
    end

    // receiver stall pattern: random runs, a stall-free mode, and a long hold-off
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 0;
        else if (!stall_on)
            out_ready <= 1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        forever
        begin
            repeat ($urandom_range(50, 400)) @(negedge clk);
            stall_on = ($urandom_range(0, 1) != 0);
        end
    end

    task automatic write_mode(bit mode);
        @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 0;
        sb.lines32 = mode;
    endtask

    task automatic send_point(logic signed [lprb_pkg::COORD_BITS-1:0] x,
                              logic signed [lprb_pkg::COORD_BITS-1:0] y,
                              logic signed [lprb_pkg::COORD_BITS-1:0] z);
        in_valid <= 1;
        x_in <= x; y_in <= y; z_in <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic gap();
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic signed [lprb_pkg::COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return lprb_pkg::COORD_BITS'($urandom);
            1: return lprb_pkg::COORD_BITS'($signed($urandom_range(0, 2047)) - 1024);
            2: return lprb_pkg::COORD_BITS'($signed($urandom_range(0, 200000)) - 100000);
            3: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return lprb_pkg::COORD_BITS'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    task automatic random_points(int n);
        int burst;
        int h;
        logic signed [lprb_pkg::COORD_BITS-1:0] x, y, z;
        while (n > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n > 0)
            begin
                x = rand_coord();
                y = rand_coord();
                if ($urandom_range(0, 2) == 0)
                    z = rand_coord();
                else
                begin
                    h = (x < 0) ? -int'(x) : int'(x);
                    h = h >>> $urandom_range(0, 3);
                    z = lprb_pkg::COORD_BITS'($signed($urandom_range(0, 2 * h + 1)) - h);
                end
                send_point(x, y, z);
                burst--; n--;
            end
            if ($urandom_range(0, 1))
                gap();
        end
        in_valid <= 0;
    endtask

    task automatic directed_points();
        send_point(0, 0, 0);
        send_point(0, 0, 1000);
        send_point(24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_point(24'sh800000, 24'sh800000, 24'sh800000);
        send_point(24'sh800000, 0, 24'sh7fffff);
        send_point(1000, 0, 0);
        send_point(-1000, 5, 0);
        send_point(1024, 0, -1);
        send_point(1024, 0, -300);
        send_point(1024, 0, 270);
        send_point(1024, 0, 2048);
        send_point(1024, 0, 2049);
        send_point(1, 0, -1);
        send_point(1, 1, 1);
        send_point(0, 24'sh7fffff, -24'sh555555);
        send_point(-1, -1, 24'sh800000);
        send_point(10000, 3000, -4000);
        send_point(10000, -3000, 5500);
        gap();
    endtask

    initial
    begin
        sb.lines32 = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1;
        directed_points();
        drain();
        write_mode(1);
        directed_points();
        random_points(300);
        drain();
        write_mode(0);
        fork
            random_points(300);
            begin
                repeat (20) @(negedge clk);
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
        join
        drain();
        write_mode(1);
        random_points(400);
        drain();
        write_mode(0);
        random_points(350);
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
